### hdl/raidpc_pkg.sv
package raidpc_pkg;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned ADDR_W     = 17;
  localparam int unsigned DISK_IDX_W = 2;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  // word_address, write_data, disk_index packed and padded to whole bytes
  localparam int unsigned S_TDATA_W  = ((ADDR_W + DATA_W + DISK_IDX_W + 7) / 8) * 8;
  // pipeline stages in one divide-by-constant unit
  localparam int unsigned CDIV_LAT   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_DROP    = 2'd2,
    CMD_REPLACE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_PARITY    = 2'd1,
    ST_UNREC     = 2'd2,
    ST_NO_PARITY = 2'd3
  } status_e;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

endpackage

### hdl/raid4_parity_array_controller_top.sv
// RAID-4 word array: DISKS disks in one shared memory, the last disk holds parity.
// Input channel s_axis_*: tuser carries the command (read, write, drop, replace),
// tdata the word address, write data and disk index. Output channel m_axis_*:
// one result transaction per command, tdata the word read or zero, tuser status.
// A command is taken only while the sequencer is idle; the previous result may
// still wait in the output register, which is held until m_axis_tready.
// Every disk access goes through one memory, with one write port and one read port,
// and one XOR accumulator that walks the disks one per cycle. An unrecoverable read
// or write skips the sweep, as does a replace of a present disk; a replace of a
// missing disk rebuilds every word of it. Only one command is in flight at a time:
// the next command is taken in the cycle after its result is loaded.
// Address decode (sector, offset, disk, row) runs through three pipelined
// divide-by-constant units on each read or write.
// After reset all DISKS * ROWS * SECTOR_WORDS memory words are swept to zero,
// one word per cycle; s_axis_tready stays low until the sweep ends.
// Reset marks all disks present and empties the output register.
module raid4_parity_array_controller_top #(
  parameter int unsigned DISKS        = 4,
  parameter int unsigned SECTOR_WORDS = 512,
  parameter int unsigned ROWS         = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [16:0] word_address, [80:17] write_data, [82:81] disk_index, rest zero
  input  logic [raidpc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // [1:0] command
  input  logic [raidpc_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [63:0] read_data
  output logic [raidpc_pkg::DATA_W-1:0]         m_axis_tdata,
  // [1:0] status
  output logic [raidpc_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int unsigned ADDR_W     = raidpc_pkg::ADDR_W;
  localparam int unsigned DATA_W     = raidpc_pkg::DATA_W;
  localparam int unsigned DISK_IDX_W = raidpc_pkg::DISK_IDX_W;
  localparam int unsigned PAR        = DISKS - 1;
  localparam int unsigned DW         = $clog2(DISKS);
  localparam int unsigned DRW        = $clog2(DISKS - 1);
  localparam int unsigned OFF_W      = $clog2(SECTOR_WORDS);
  localparam int unsigned ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned DISK_WORDS = ROWS * SECTOR_WORDS;
  localparam int unsigned WW         = $clog2(DISK_WORDS);
  localparam int unsigned MEM_DEPTH  = DISKS * DISK_WORDS;
  localparam int unsigned MAW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [DISKS-1:0] ONE_BIT = DISKS'(1);
  localparam logic [DISKS-1:0] PAR_BIT = ONE_BIT << PAR;
  localparam logic [2:0] DEC_LAST = 3'(3 * raidpc_pkg::CDIV_LAT - 1);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_DECODE  = 10'b00_0000_0100,
    S_PLAN    = 10'b00_0000_1000,
    S_SWEEP   = 10'b00_0001_0000,
    S_DRAIN   = 10'b00_0010_0000,
    S_WR_DATA = 10'b00_0100_0000,
    S_WR_PAR  = 10'b00_1000_0000,
    S_WR_REB  = 10'b01_0000_0000,
    S_FIN     = 10'b10_0000_0000
  } state_e;

  function automatic logic [MAW-1:0] slot(input logic [DW-1:0] d, input logic [WW-1:0] w);
    return MAW'(d) * MAW'(DISK_WORDS) + MAW'(w);
  endfunction

  // control state
  state_e             state_q, state_d;
  logic [DISKS-1:0]   present_q, present_d;
  logic               out_valid_q, out_valid_d;
  logic               rvalid_q, rvalid_d;
  logic [MAW-1:0]     clr_q, clr_d;

  // item and sequencer payload
  raidpc_pkg::cmd_e    cmd_q, cmd_d;
  raidpc_pkg::status_e status_q, status_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [DATA_W-1:0]     wdata_q, wdata_d;
  logic [DISK_IDX_W-1:0] di_q, di_d;
  logic [2:0]            dec_cnt_q, dec_cnt_d;
  logic [DW-1:0]         disk_q, disk_d;
  logic [WW-1:0]         w_q, w_d;
  logic [DISKS-1:0]      mask_q, mask_d;
  logic [DW-1:0]         sweep_q, sweep_d;
  logic [DW-1:0]         rdisk_q, rdisk_d;
  logic                  rebuild_q, rebuild_d;
  logic                  wr_data_q, wr_data_d;
  logic                  wr_par_q, wr_par_d;
  logic [DATA_W-1:0]     out_data_q, out_data_d;
  logic [raidpc_pkg::STATUS_W-1:0] out_status_q, out_status_d;

  // decode and datapath
  logic [ADDR_W-1:0] sector;
  logic [OFF_W-1:0]  off;
  logic [ADDR_W-1:0] quo2;
  logic [DRW-1:0]    disk_r;
  logic [ROW_W-1:0]  row_r;
  logic [DW-1:0]     disk_sel;
  logic [DISKS-1:0]  dbit;
  logic [DISKS-1:0]  di_bit;
  logic              disk_ok;
  logic              oth_disk;
  logic              oth_di;
  logic              di_missing;

  logic              mem_we;
  logic [MAW-1:0]    mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [MAW-1:0]    mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  raidpc_pkg::acc_ctrl_t acc_ctrl;
  logic [DATA_W-1:0]     acc;

  raidpc_cdiv #(.XW(ADDR_W), .DIV(SECTOR_WORDS)) u_cdiv_sector (
    .clk_i (clk_i),
    .x_i   (addr_q),
    .q_o   (sector),
    .r_o   (off)
  );

  raidpc_cdiv #(.XW(ADDR_W), .DIV(DISKS - 1)) u_cdiv_disk (
    .clk_i (clk_i),
    .x_i   (sector),
    .q_o   (quo2),
    .r_o   (disk_r)
  );

  raidpc_cdiv #(.XW(ADDR_W), .DIV(ROWS)) u_cdiv_row (
    .clk_i (clk_i),
    .x_i   (quo2),
    .q_o   (),
    .r_o   (row_r)
  );

  raidpc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  raidpc_xacc u_xacc (
    .clk_i  (clk_i),
    .ctrl_i (acc_ctrl),
    .data_i (mem_rdata),
    .acc_o  (acc)
  );

  always_comb begin
    disk_sel   = DW'(disk_r);
    dbit       = ONE_BIT << disk_sel;
    di_bit     = ONE_BIT << di_q;
    disk_ok    = |(present_q & dbit);
    oth_disk   = &(present_q | dbit);
    oth_di     = &(present_q | di_bit);
    di_missing = (di_bit != '0) && ((present_q & di_bit) == '0);
  end

  always_comb begin
    state_d      = state_q;
    present_d    = present_q;
    rvalid_d     = 1'b0;
    clr_d        = clr_q;
    cmd_d        = cmd_q;
    status_d     = status_q;
    addr_d       = addr_q;
    wdata_d      = wdata_q;
    di_d         = di_q;
    dec_cnt_d    = dec_cnt_q;
    disk_d       = disk_q;
    w_d          = w_q;
    mask_d       = mask_q;
    sweep_d      = sweep_q;
    rdisk_d      = rdisk_q;
    rebuild_d    = rebuild_q;
    wr_data_d    = wr_data_q;
    wr_par_d     = wr_par_q;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;

    mem_we    = 1'b0;
    mem_waddr = slot(disk_q, w_q);
    mem_wdata = wdata_q;
    mem_re    = 1'b0;
    mem_raddr = slot(sweep_q, w_q);

    acc_ctrl.clear = 1'b0;
    acc_ctrl.add   = rvalid_q && mask_q[rdisk_q];

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + MAW'(1);
        if (clr_q == MAW'(MEM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d     = raidpc_pkg::cmd_e'(s_axis_tuser);
          addr_d    = s_axis_tdata[ADDR_W-1:0];
          wdata_d   = s_axis_tdata[ADDR_W +: DATA_W];
          di_d      = s_axis_tdata[ADDR_W + DATA_W +: DISK_IDX_W];
          dec_cnt_d = '0;
          if (cmd_d == raidpc_pkg::CMD_READ || cmd_d == raidpc_pkg::CMD_WRITE) begin
            state_d = S_DECODE;
          end else begin
            state_d = S_PLAN;
          end
        end
      end
      S_DECODE: begin
        dec_cnt_d = dec_cnt_q + 3'd1;
        if (dec_cnt_q == DEC_LAST) begin
          state_d = S_PLAN;
        end
      end
      S_PLAN: begin
        acc_ctrl.clear = 1'b1;
        sweep_d   = '0;
        rebuild_d = 1'b0;
        wr_data_d = 1'b0;
        wr_par_d  = 1'b0;
        disk_d    = disk_sel;
        w_d       = WW'(row_r) * WW'(SECTOR_WORDS) + WW'(off);
        mask_d    = '0;
        status_d  = raidpc_pkg::ST_OK;
        state_d   = S_FIN;
        case (cmd_q)
          raidpc_pkg::CMD_READ: begin
            if (disk_ok) begin
              mask_d  = dbit;
              state_d = S_SWEEP;
            end else if (oth_disk) begin
              mask_d   = ~dbit;
              status_d = raidpc_pkg::ST_PARITY;
              state_d  = S_SWEEP;
            end else begin
              status_d = raidpc_pkg::ST_UNREC;
            end
          end
          raidpc_pkg::CMD_WRITE: begin
            // new parity is always acc ^ write data: acc holds old data ^ old
            // parity, or the XOR of the surviving data disks
            if (disk_ok) begin
              mask_d    = dbit | PAR_BIT;
              wr_data_d = 1'b1;
              wr_par_d  = present_q[PAR];
              status_d  = present_q[PAR] ? raidpc_pkg::ST_OK : raidpc_pkg::ST_NO_PARITY;
              state_d   = S_SWEEP;
            end else if (oth_disk) begin
              mask_d   = ~(dbit | PAR_BIT);
              wr_par_d = 1'b1;
              status_d = raidpc_pkg::ST_PARITY;
              state_d  = S_SWEEP;
            end else begin
              status_d = raidpc_pkg::ST_UNREC;
            end
          end
          raidpc_pkg::CMD_DROP: begin
            present_d = present_q & ~di_bit;
          end
          raidpc_pkg::CMD_REPLACE: begin
            if (di_missing) begin
              rebuild_d = 1'b1;
              disk_d    = DW'(di_q);
              w_d       = '0;
              // with a second disk gone the sweep adds nothing: words come back zero
              mask_d    = oth_di ? ~di_bit : '0;
              status_d  = oth_di ? raidpc_pkg::ST_OK : raidpc_pkg::ST_UNREC;
              present_d = present_q | di_bit;
              state_d   = S_SWEEP;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_SWEEP: begin
        mem_re   = 1'b1;
        rvalid_d = 1'b1;
        rdisk_d  = sweep_q;
        if (sweep_q == DW'(PAR)) begin
          state_d = S_DRAIN;
        end else begin
          sweep_d = sweep_q + DW'(1);
        end
      end
      S_DRAIN: begin
        if (rebuild_q) begin
          state_d = S_WR_REB;
        end else if (wr_data_q) begin
          state_d = S_WR_DATA;
        end else if (wr_par_q) begin
          state_d = S_WR_PAR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_WR_DATA: begin
        mem_we  = 1'b1;
        state_d = wr_par_q ? S_WR_PAR : S_FIN;
      end
      S_WR_PAR: begin
        mem_we    = 1'b1;
        mem_waddr = slot(DW'(PAR), w_q);
        mem_wdata = acc ^ wdata_q;
        state_d   = S_FIN;
      end
      S_WR_REB: begin
        mem_we    = 1'b1;
        mem_wdata = acc;
        if (w_q == WW'(DISK_WORDS - 1)) begin
          state_d = S_FIN;
        end else begin
          w_d            = w_q + WW'(1);
          sweep_d        = '0;
          acc_ctrl.clear = 1'b1;
          state_d        = S_SWEEP;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_data_d   = (cmd_q == raidpc_pkg::CMD_READ && status_q != raidpc_pkg::ST_UNREC)
                         ? acc : '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      present_q   <= '1;
      out_valid_q <= 1'b0;
      rvalid_q    <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      out_valid_q <= out_valid_d;
      rvalid_q    <= rvalid_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    status_q     <= status_d;
    addr_q       <= addr_d;
    wdata_q      <= wdata_d;
    di_q         <= di_d;
    dec_cnt_q    <= dec_cnt_d;
    disk_q       <= disk_d;
    w_q          <= w_d;
    mask_q       <= mask_d;
    sweep_q      <= sweep_d;
    rdisk_q      <= rdisk_d;
    rebuild_q    <= rebuild_d;
    wr_data_q    <= wr_data_d;
    wr_par_q     <= wr_par_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

### hdl/raidpc_ram.sv
module raidpc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/raidpc_cdiv.sv
module raidpc_cdiv #(
  parameter int unsigned XW  = 17,
  parameter int unsigned DIV = 3,
  localparam int unsigned RW = (DIV > 1) ? $clog2(DIV) : 1
) (
  input  logic          clk_i,
  input  logic [XW-1:0] x_i,
  output logic [XW-1:0] q_o,
  output logic [RW-1:0] r_o
);

  // Exact reciprocal: floor(x * M / 2^S) == floor(x / DIV) for every x < 2^XW
  localparam int unsigned L  = $clog2(DIV);
  localparam int unsigned S  = XW + L;
  localparam int unsigned MW = XW + 1;
  localparam int unsigned PW = XW + MW;
  localparam longint unsigned M = ((64'd1 << S) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [XW-1:0] DIV_K = XW'(DIV);

  logic [XW-1:0] x1_q;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] shifted;
  logic [XW-1:0] quo;
  logic [XW-1:0] rem_full;
  logic [XW-1:0] q_q;
  logic [RW-1:0] r_q;

  always_ff @(posedge clk_i) begin
    x1_q   <= x_i;
    prod_q <= {{MW{1'b0}}, x_i} * PW'(M);
  end

  always_comb begin
    shifted  = prod_q >> S;
    quo      = shifted[XW-1:0];
    rem_full = x1_q - XW'(quo * DIV_K);
  end

  always_ff @(posedge clk_i) begin
    q_q <= quo;
    r_q <= rem_full[RW-1:0];
  end

  assign q_o = q_q;
  assign r_o = r_q;

endmodule

### hdl/raidpc_xacc.sv
module raidpc_xacc (
  input  logic                              clk_i,
  input  raidpc_pkg::acc_ctrl_t             ctrl_i,
  input  logic [raidpc_pkg::DATA_W-1:0]     data_i,
  output logic [raidpc_pkg::DATA_W-1:0]     acc_o
);

  logic [raidpc_pkg::DATA_W-1:0] acc_q;
  logic [raidpc_pkg::DATA_W-1:0] acc_d;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.add) begin
      acc_d = acc_q ^ data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule
